// ===== hdl/stq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stq_pkg: shared types and constants for the sorted countdown task queue
// Operation codes, controller states and the controller-to-datapath command.
// ----------------------------------------------------------------------------
package stq_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 16;
    localparam int MODE_W              = 2;
    localparam int ID_W                = 8;
    localparam int CD_W                = 32;
    localparam int COUNT_OUT_W         = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD   = 2'd0,
        MODE_TICK  = 2'd1,
        MODE_POP   = 2'd2,
        MODE_QUERY = 2'd3
    } mode_t;

    typedef enum logic {
        OUT_IDLE = 1'b0,
        OUT_PEND = 1'b1
    } out_state_t;

    typedef struct packed {
        logic  apply;
        mode_t mode;
    } dp_cmd_t;

endpackage
`default_nettype wire

// ===== hdl/stq_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stq_ctrl: handshake controller
// Tracks the result slot and issues one apply command per accepted transaction.
// ----------------------------------------------------------------------------
module stq_ctrl (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [stq_pkg::MODE_W-1:0]  s_mode,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output stq_pkg::dp_cmd_t                 cmd
);

    stq_pkg::out_state_t state_reg, state_next;
    logic accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= stq_pkg::OUT_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            stq_pkg::OUT_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = stq_pkg::OUT_PEND;
                end
            end
            stq_pkg::OUT_PEND: begin
                m_valid = 1'b1;
                // a new transaction may enter as the pending result leaves
                s_ready = m_ready;
                if (m_ready && !s_valid) begin
                    state_next = stq_pkg::OUT_IDLE;
                end
            end
            default: begin
                state_next = stq_pkg::OUT_IDLE;
            end
        endcase
        accept    = s_valid && s_ready;
        cmd.apply = accept;
        cmd.mode  = stq_pkg::mode_t'(s_mode);
    end

    assert property (@(posedge aclk) disable iff (!aresetn) accept |=> m_valid)
        else $error("accepted transaction did not raise m_valid");
    assert property (@(posedge aclk) disable iff (!aresetn)
            (m_valid && !m_ready) |=> m_valid)
        else $error("m_valid dropped before the result was taken");
    assert property (@(posedge aclk) disable iff (!aresetn)
            s_ready |-> (!m_valid || m_ready))
        else $error("input taken while a result is held");

endmodule
`default_nettype wire

// ===== hdl/stq_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stq_datapath: row of queue cells
// Each cell compares, shifts and decrements in parallel; cell 0 is the head.
// ----------------------------------------------------------------------------
module stq_datapath #(
    parameter int QUEUE_DEPTH = stq_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire stq_pkg::dp_cmd_t                  cmd,
    input  wire logic [stq_pkg::ID_W-1:0]          s_task_id,
    input  wire logic [stq_pkg::CD_W-1:0]          s_delay,
    output logic                                   m_head_due,
    output logic [stq_pkg::ID_W-1:0]               m_head_id,
    output logic [stq_pkg::COUNT_OUT_W-1:0]        m_entry_count,
    output logic                                   m_add_refused
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int EXT_W = (CNT_W > stq_pkg::COUNT_OUT_W) ? CNT_W : stq_pkg::COUNT_OUT_W;

    logic [stq_pkg::ID_W-1:0] id_reg [QUEUE_DEPTH];
    logic [stq_pkg::CD_W-1:0] cd_reg [QUEUE_DEPTH];
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     refused_reg, refused_next;
    logic [QUEUE_DEPTH-1:0]   valid;
    logic [QUEUE_DEPTH-1:0]   gt;
    logic                     full;
    logic [EXT_W-1:0]         count_ext;

    assign full = (count_reg == CNT_W'(QUEUE_DEPTH));

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        logic [stq_pkg::ID_W-1:0] id_next;
        logic [stq_pkg::CD_W-1:0] cd_next;
        logic                     ins_here;
        logic                     shift_in;

        assign valid[i] = (count_reg > CNT_W'(i));
        assign gt[i]    = valid[i] && (cd_reg[i] > s_delay);

        // new entry lands in the first slot that is empty or holds a later countdown
        if (i == 0) begin : g_head
            assign ins_here = gt[i] || !valid[i];
            assign shift_in = 1'b0;
        end else begin : g_body
            assign ins_here = (gt[i] || !valid[i]) && valid[i-1] && !gt[i-1];
            assign shift_in = gt[i-1];
        end

        always_comb begin
            id_next = id_reg[i];
            cd_next = cd_reg[i];
            if (cmd.apply) begin
                unique case (cmd.mode)
                    stq_pkg::MODE_ADD: begin
                        if (!full) begin
                            if (ins_here) begin
                                id_next = s_task_id;
                                cd_next = s_delay;
                            end else if (shift_in) begin
                                id_next = id_reg[(i > 0) ? i - 1 : 0];
                                cd_next = cd_reg[(i > 0) ? i - 1 : 0];
                            end
                        end
                    end
                    stq_pkg::MODE_TICK: begin
                        if (cd_reg[i] != '0) begin
                            cd_next = cd_reg[i] - 1'b1;
                        end
                    end
                    stq_pkg::MODE_POP: begin
                        if (i < QUEUE_DEPTH - 1) begin
                            id_next = id_reg[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
                            cd_next = cd_reg[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
                        end
                    end
                    stq_pkg::MODE_QUERY: begin
                    end
                endcase
            end
        end

        always_ff @(posedge aclk) begin
            id_reg[i] <= id_next;
            cd_reg[i] <= cd_next;
        end
    end

    always_comb begin
        count_next   = count_reg;
        refused_next = refused_reg;
        if (cmd.apply) begin
            refused_next = 1'b0;
            unique case (cmd.mode) inside
                stq_pkg::MODE_ADD: begin
                    if (full) begin
                        refused_next = 1'b1;
                    end else begin
                        count_next = count_reg + 1'b1;
                    end
                end
                stq_pkg::MODE_POP: begin
                    if (count_reg != '0) begin
                        count_next = count_reg - 1'b1;
                    end
                end
                stq_pkg::MODE_TICK, stq_pkg::MODE_QUERY: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            refused_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            refused_reg <= refused_next;
        end
    end

    assign count_ext     = EXT_W'(count_reg);
    assign m_entry_count = count_ext[stq_pkg::COUNT_OUT_W-1:0];
    assign m_head_due    = valid[0] && (cd_reg[0] == '0);
    assign m_head_id     = valid[0] ? id_reg[0] : '0;
    assign m_add_refused = refused_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
            count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above queue depth");
    assert property (@(posedge aclk) disable iff (!aresetn)
            (cmd.apply && cmd.mode == stq_pkg::MODE_ADD && full)
            |=> (refused_reg && $stable(count_reg)))
        else $error("add to full queue not refused");
    assert property (@(posedge aclk) disable iff (!aresetn)
            (cmd.apply && cmd.mode == stq_pkg::MODE_POP && count_reg != '0)
            |=> (count_reg == CNT_W'($past(count_reg) - 1'b1)))
        else $error("pop did not remove one entry");

endmodule
`default_nettype wire

// ===== hdl/sorted_countdown_task_queue_unit.sv =====
`default_nettype none
// Latency: the result of a transaction is valid the cycle after it is accepted.
// Throughput: one transaction per cycle; every cell updates in the accept cycle
// and the result slot frees as it is taken, so s_ready stays high under m_ready.
// Reset: aresetn clears the entry count, the refused flag and the result slot;
// entry contents stay undefined until written and never reach an output unless valid.
// ----------------------------------------------------------------------------
// sorted_countdown_task_queue_unit: sorted countdown task queue
// Keeps task entries sorted by countdown; add, tick, pop and query per item.
// ----------------------------------------------------------------------------
module sorted_countdown_task_queue_unit #(
    parameter int QUEUE_DEPTH = stq_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [stq_pkg::MODE_W-1:0]         s_mode,
    input  wire logic [stq_pkg::ID_W-1:0]           s_task_id,
    input  wire logic [stq_pkg::CD_W-1:0]           s_delay,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic                                    m_head_due,
    output logic [stq_pkg::ID_W-1:0]                m_head_id,
    output logic [stq_pkg::COUNT_OUT_W-1:0]         m_entry_count,
    output logic                                    m_add_refused
);

    stq_pkg::dp_cmd_t cmd;

    stq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_mode  (s_mode),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    stq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .s_task_id     (s_task_id),
        .s_delay       (s_delay),
        .m_head_due    (m_head_due),
        .m_head_id     (m_head_id),
        .m_entry_count (m_entry_count),
        .m_add_refused (m_add_refused)
    );

endmodule
`default_nettype wire
